### hw/rtl/tcpreno_pkg.sv
// ============================================================================
// tcpreno_pkg - shared types and constants of the Reno congestion controller
// Field widths, event and mode codes, register indexes, reset values and the
// structures passed between the front end, the queue and the execution unit.
// ============================================================================
package tcpreno_pkg;

  // Largest congestion window in segments; growth saturates here.
  localparam int unsigned MAX_WINDOW = 65535;

  localparam int unsigned WIN_W      = 16;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned US_W       = 32;
  localparam int unsigned DUP_W      = 4;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 120;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);
  localparam logic [DUP_W-1:0] DUP_MAX = '1;

  // Event codes as they arrive on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_WIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TMO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RTT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THR   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [WIN_W-1:0] RST_RECV_WIN = 16'd64;
  localparam logic [WIN_W-1:0] RST_INIT_THR = 16'd64;
  localparam logic [US_W-1:0]  RST_INIT_TMO = 32'd40000;
  localparam logic [US_W-1:0]  RST_INIT_RTT = 32'd20000;
  localparam logic [SEQ_W-1:0] RST_INIT_SEQ = 32'd127;
  localparam logic [DUP_W-1:0] RST_DUP_THR  = 4'd3;

  typedef enum logic [1:0] {
    EV_START,
    EV_ACK,
    EV_TIMEOUT,
    EV_NOP
  } event_t;

  typedef enum logic [1:0] {
    MODE_SLOW,
    MODE_AVOID,
    MODE_RECOVER
  } mode_t;

  typedef enum logic [1:0] {
    RETX_NONE,
    RETX_FAST,
    RETX_TIMEOUT
  } retx_t;

  typedef struct packed {
    event_t           ev;
    logic [SEQ_W-1:0] ack_number;
    logic [US_W-1:0]  rtt_sample;
    logic             sample_valid;
    logic             all_acked;
  } item_t;

  typedef struct packed {
    logic [WIN_W-1:0] receive_window;
    logic [WIN_W-1:0] initial_threshold;
    logic [US_W-1:0]  initial_timeout;
    logic [US_W-1:0]  initial_rtt;
    logic [SEQ_W-1:0] initial_sequence;
    logic [DUP_W-1:0] dup_threshold;
  } cfg_t;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [WIN_W-1:0] threshold;
    logic [WIN_W-1:0] send_limit;
    mode_t            mode;
    retx_t            retransmit_kind;
    logic [SEQ_W-1:0] retransmit_seq;
    logic [US_W-1:0]  timeout_us;
  } res_t;

  // Window growth with saturation at the maximum window.
  function automatic logic [WIN_W-1:0] grow_window(input logic [WIN_W-1:0] w,
                                                   input logic [WIN_W-1:0] add);
    logic [WIN_W:0] sum;
    sum = {1'b0, w} + {1'b0, add};
    if (sum > {1'b0, WIN_MAX}) begin
      return WIN_MAX;
    end
    return sum[WIN_W-1:0];
  endfunction

endpackage

### hw/rtl/tcpreno_front.sv
// ============================================================================
// tcpreno_front - input stage of the Reno congestion controller
// Accepts event requests, decodes the event code and registers the item
// for the queue in front of the execution unit.
// ============================================================================
module tcpreno_front
  import tcpreno_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  output logic                  q_wr_valid,
  input  logic                  q_wr_ready,
  output item_t                 q_wr_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  // Unknown event codes become a no-op that just reports the state.
  always_comb begin
    case (in_tuser)
      FUNC_START:   item_nxt.ev = EV_START;
      FUNC_ACK:     item_nxt.ev = EV_ACK;
      FUNC_TIMEOUT: item_nxt.ev = EV_TIMEOUT;
      default:      item_nxt.ev = EV_NOP;
    endcase
    item_nxt.ack_number   = in_tdata[SEQ_W-1:0];
    item_nxt.rtt_sample   = in_tdata[SEQ_W+US_W-1:SEQ_W];
    item_nxt.sample_valid = in_tdata[SEQ_W+US_W];
    item_nxt.all_acked    = in_tdata[SEQ_W+US_W+1];
  end

  assign in_tready  = !valid_r || q_wr_ready;
  assign q_wr_valid = valid_r;
  assign q_wr_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

endmodule

### hw/rtl/tcpreno_queue.sv
// ============================================================================
// tcpreno_queue - short event queue between front end and execution unit
// A small register FIFO so that each side can stall on its own.
// ============================================================================
module tcpreno_queue
  import tcpreno_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_pop,
  output item_t rd_item
);

  item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   wr_en;
  logic                   rd_en;

  assign wr_ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_pop && rd_valid;

  function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

### hw/rtl/tcpreno_back.sv
// ============================================================================
// tcpreno_back - execution unit of the Reno congestion controller
// Applies one event to the window state, runs the round trip estimator
// over three extra steps when an advancing ack carries a sample, and holds the result.
// ============================================================================
module tcpreno_back
  import tcpreno_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_DIFF,
    ST_DEV,
    ST_TMO
  } state_t;

  state_t           state_r,  state_nxt;
  logic [WIN_W-1:0] cw_r,     cw_nxt;
  logic [WIN_W-1:0] thr_r,    thr_nxt;
  mode_t            mode_r,   mode_nxt;
  logic [DUP_W-1:0] dup_r,    dup_nxt;
  logic [SEQ_W-1:0] base_r,   base_nxt;
  logic [US_W-1:0]  srtt_r,   srtt_nxt;
  logic [US_W-1:0]  dev_r,    dev_nxt;
  logic [US_W-1:0]  tmo_r,    tmo_nxt;
  logic [US_W-1:0]  sample_r, sample_nxt;
  logic [US_W-1:0]  diff_r,   diff_nxt;
  res_t             pend_r,   pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r,   out_res_nxt;

  // Outcome of the event at the head of the queue.
  logic [WIN_W-1:0] ex_cw, ex_thr, ex_limit, cw_mid, thr_mid, rw_eff;
  mode_t            ex_mode, mode_mid;
  logic [DUP_W-1:0] ex_dup, dup_inc;
  logic [SEQ_W-1:0] ex_base, ex_seq;
  logic [US_W-1:0]  ex_srtt, ex_dev, ex_tmo;
  retx_t            ex_kind;
  logic             ack_eq, ack_gt, fire, rtt_go, out_free;
  res_t             ex_res;

  // Estimator arithmetic, one wide add per step.
  logic [US_W+2:0]  srtt_sum;
  logic [US_W+1:0]  dev_sum;
  logic [US_W+1:0]  tmo_sum;
  logic [US_W-1:0]  tmo_sat;

  assign ack_eq   = (q_item.ack_number == base_r);
  assign ack_gt   = (q_item.ack_number > base_r);
  assign dup_inc  = (dup_r < DUP_MAX) ? dup_r + 1'b1 : dup_r;
  assign fire     = (cfg.dup_threshold != '0) && (dup_inc == cfg.dup_threshold);
  assign rw_eff   = (cfg.receive_window == '0) ? WIN_W'(1) : cfg.receive_window;
  assign rtt_go   = (q_item.ev == EV_ACK) && ack_gt && q_item.sample_valid;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    ex_cw    = cw_r;
    ex_thr   = thr_r;
    ex_mode  = mode_r;
    ex_dup   = dup_r;
    ex_base  = base_r;
    ex_srtt  = srtt_r;
    ex_dev   = dev_r;
    ex_tmo   = tmo_r;
    ex_kind  = RETX_NONE;
    ex_seq   = '0;
    cw_mid   = cw_r;
    thr_mid  = thr_r;
    mode_mid = mode_r;
    case (q_item.ev)
      EV_START: begin
        ex_cw   = WIN_W'(1);
        ex_thr  = (cfg.initial_threshold == '0) ? WIN_W'(1) : cfg.initial_threshold;
        ex_mode = MODE_SLOW;
        ex_dup  = '0;
        ex_base = cfg.initial_sequence;
        ex_srtt = cfg.initial_rtt;
        ex_dev  = '0;
        ex_tmo  = cfg.initial_timeout;
      end
      EV_ACK: begin
        if (ack_eq) begin
          ex_dup = dup_inc;
          if (fire) begin
            // Duplicate ack limit reached: fast retransmit, halve the window.
            ex_kind  = RETX_FAST;
            ex_seq   = q_item.ack_number;
            ex_dup   = '0;
            cw_mid   = (cw_r > WIN_W'(1)) ? (cw_r >> 1) : cw_r;
            thr_mid  = cw_mid;
            mode_mid = MODE_RECOVER;
          end
        end else if (ack_gt) begin
          if (mode_r == MODE_RECOVER) begin
            cw_mid   = grow_window(cw_r, WIN_W'(1));
            mode_mid = MODE_AVOID;
          end
          ex_dup  = '0;
          ex_base = q_item.ack_number;
        end
        if ((mode_mid == MODE_SLOW) && (cw_mid >= thr_mid)) begin
          mode_mid = MODE_AVOID;
        end
        if (q_item.all_acked) begin
          ex_cw = grow_window(cw_mid, (mode_mid == MODE_SLOW) ? cw_mid : WIN_W'(1));
        end else begin
          ex_cw = cw_mid;
        end
        ex_thr  = thr_mid;
        ex_mode = mode_mid;
      end
      EV_TIMEOUT: begin
        ex_thr  = ((cw_r >> 1) == '0) ? WIN_W'(1) : (cw_r >> 1);
        ex_cw   = WIN_W'(1);
        ex_mode = MODE_SLOW;
        if (!q_item.all_acked) begin
          ex_kind = RETX_TIMEOUT;
          ex_seq  = base_r;
        end
      end
      default: begin
      end
    endcase
    ex_limit = (rw_eff < ex_cw) ? rw_eff : ex_cw;

    ex_res.window          = ex_cw;
    ex_res.threshold       = ex_thr;
    ex_res.send_limit      = ex_limit;
    ex_res.mode            = ex_mode;
    ex_res.retransmit_kind = ex_kind;
    ex_res.retransmit_seq  = ex_seq;
    ex_res.timeout_us      = ex_tmo;
  end

  // New smoothed estimate: (7*srtt + sample) / 8.
  assign srtt_sum = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, q_item.rtt_sample};
  // New deviation: (3*dev + |srtt - sample|) / 4.
  assign dev_sum  = {1'b0, dev_r, 1'b0} + {2'b00, dev_r} + {2'b00, diff_r};
  // Timeout = srtt + 4*dev, saturated to 32 bits.
  assign tmo_sum  = {2'b00, srtt_r} + {dev_r, 2'b00};
  assign tmo_sat  = (tmo_sum[US_W+1:US_W] != 2'b00) ? '1 : tmo_sum[US_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cw_nxt        = cw_r;
    thr_nxt       = thr_r;
    mode_nxt      = mode_r;
    dup_nxt       = dup_r;
    base_nxt      = base_r;
    srtt_nxt      = srtt_r;
    dev_nxt       = dev_r;
    tmo_nxt       = tmo_r;
    sample_nxt    = sample_r;
    diff_nxt      = diff_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_EXEC: begin
        if (q_valid && (rtt_go || out_free)) begin
          q_pop    = 1'b1;
          cw_nxt   = ex_cw;
          thr_nxt  = ex_thr;
          mode_nxt = ex_mode;
          dup_nxt  = ex_dup;
          base_nxt = ex_base;
          if (rtt_go) begin
            srtt_nxt   = srtt_sum[US_W+2:3];
            sample_nxt = q_item.rtt_sample;
            pend_nxt   = ex_res;
            state_nxt  = ST_DIFF;
          end else begin
            srtt_nxt      = ex_srtt;
            dev_nxt       = ex_dev;
            tmo_nxt       = ex_tmo;
            out_valid_nxt = 1'b1;
            out_res_nxt   = ex_res;
          end
        end
      end
      ST_DIFF: begin
        diff_nxt  = (srtt_r >= sample_r) ? srtt_r - sample_r : sample_r - srtt_r;
        state_nxt = ST_DEV;
      end
      ST_DEV: begin
        dev_nxt   = dev_sum[US_W+1:2];
        state_nxt = ST_TMO;
      end
      ST_TMO: begin
        if (out_free) begin
          tmo_nxt                = tmo_sat;
          out_valid_nxt          = 1'b1;
          out_res_nxt            = pend_r;
          out_res_nxt.timeout_us = tmo_sat;
          state_nxt              = ST_EXEC;
        end
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      cw_r        <= WIN_W'(1);
      thr_r       <= RST_INIT_THR;
      mode_r      <= MODE_SLOW;
      dup_r       <= '0;
      base_r      <= RST_INIT_SEQ;
      srtt_r      <= RST_INIT_RTT;
      dev_r       <= '0;
      tmo_r       <= RST_INIT_TMO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cw_r        <= cw_nxt;
      thr_r       <= thr_nxt;
      mode_r      <= mode_nxt;
      dup_r       <= dup_nxt;
      base_r      <= base_nxt;
      srtt_r      <= srtt_nxt;
      dev_r       <= dev_nxt;
      tmo_r       <= tmo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    diff_r    <= diff_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hw/rtl/tcp_reno_congestion_control_unit.sv
// ============================================================================
// tcp_reno_congestion_control_unit - sender-side Reno congestion controller
// Throughput: one event per cycle while results are taken; an ack that advances the send
//   base with a valid RTT sample holds the execution unit for its estimator steps.
// Reset (rst_n low, synchronous): control registers, configuration and state take their defaults.
// ============================================================================
//
// Structure. A front stage takes input requests, decodes the event code and
// registers the item. A two-entry queue decouples it from the execution
// unit, which applies the event to the congestion state and loads a result
// register. That register holds a result until the consumer takes it; while
// it waits, only an advancing ack with an RTT sample starts, then stalls at ST_TMO.
//
// Round trip estimation runs in three extra steps on the execution unit:
// the new smoothed value is formed with the window update, then the absolute
// error, then the new deviation, and finally the saturated retransmit timeout.
// All other events finish in the cycle they leave the queue.
//
// Configuration is written through a plain write port, one register per
// index; writes are expected only while no request is in flight.
module tcp_reno_congestion_control_unit
  import tcpreno_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Event requests.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] ack_number, [63:32] rtt_sample, [64] sample_valid, [65] all_acked
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]      in_tuser,
  // Results, one per event.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] window, [31:16] threshold, [47:32] send_limit, [49:48] mode,
  // [81:50] retransmit_seq, [113:82] timeout_us
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] retransmit_kind
  output logic [1:0]             out_tuser,
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r;
  logic  q_wr_valid;
  logic  q_wr_ready;
  item_t q_wr_item;
  logic  q_rd_valid;
  logic  q_pop;
  item_t q_rd_item;
  res_t  res;

  // Register writes; data is truncated to the width of the register and
  // writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.receive_window    <= RST_RECV_WIN;
      cfg_r.initial_threshold <= RST_INIT_THR;
      cfg_r.initial_timeout   <= RST_INIT_TMO;
      cfg_r.initial_rtt       <= RST_INIT_RTT;
      cfg_r.initial_sequence  <= RST_INIT_SEQ;
      cfg_r.dup_threshold     <= RST_DUP_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECV_WIN: cfg_r.receive_window    <= cfg_wdata[WIN_W-1:0];
        CFG_INIT_THR: cfg_r.initial_threshold <= cfg_wdata[WIN_W-1:0];
        CFG_INIT_TMO: cfg_r.initial_timeout   <= cfg_wdata[US_W-1:0];
        CFG_INIT_RTT: cfg_r.initial_rtt       <= cfg_wdata[US_W-1:0];
        CFG_INIT_SEQ: cfg_r.initial_sequence  <= cfg_wdata[SEQ_W-1:0];
        CFG_DUP_THR:  cfg_r.dup_threshold     <= cfg_wdata[DUP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcpreno_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_item  (q_wr_item)
  );

  tcpreno_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_rd_item)
  );

  tcpreno_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_rd_valid),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'b000000, res.timeout_us, res.retransmit_seq, res.mode,
                      res.send_limit, res.threshold, res.window};
  assign out_tuser = res.retransmit_kind;

endmodule
